### src/blm_pkg.sv
// Package for the battery level monitor: window size, field widths,
// scaling constants, register indexes and the divider control structs.
// No dependencies.
package blm_pkg;

   localparam int WINDOW        = 20;
   localparam int ADC_BITS      = 10;
   localparam int ADC_MAX       = (1 << ADC_BITS) - 1;
   localparam int FULL_SCALE_MV = 3300;
   localparam int NOISE_FLOOR   = 10;
   localparam int LEVEL_MAX     = 1000;

   localparam int MV_W    = 12;
   localparam int LVL_W   = 10;
   localparam int HYST_W  = 10;
   localparam int WPOS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W   = $clog2(ADC_MAX * WINDOW + 1);
   localparam int AVG_DIV = ADC_MAX * WINDOW;
   localparam int PROD_W  = $clog2(AVG_DIV * FULL_SCALE_MV + 1);
   localparam int DIV_W   = $clog2(AVG_DIV + 1);
   localparam int REM_W   = DIV_W + 1;
   localparam int Q_W     = MV_W;
   localparam int CNT_W   = $clog2(Q_W + 1);
   localparam int LVL_PROD_W = MV_W + LVL_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = MV_W;

   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HYST  = 2'd2;

   localparam logic [MV_W-1:0]   EMPTY_RESET = 12'd2654;
   localparam logic [MV_W-1:0]   FULL_RESET  = 12'd3008;
   localparam logic [HYST_W-1:0] HYST_RESET  = 10'd5;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] steps;
      logic [REM_W-1:0] rem_init;
      logic [Q_W-1:0]   low_init;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic           done;
      logic [Q_W-1:0] quotient;
   } div_rsp_type;

endpackage

### src/battery_level_monitor_unit.sv
// Battery level monitor top level: sample ring, running sum, sequencer,
// hysteresis and result register. Depends on blm_pkg and blm_div.
//
// Usage: one ADC sample is a beat on the req_ channel (valid/ready). Each
// beat yields one rsp_ beat carrying the window average in millivolts and
// the held charge level in tenths of a percent. The csr_ port writes the
// empty level, full level and hysteresis; write only while idle.
// The level needs no division when a compare settles it (average at or
// below empty, full at or below empty, or average at or above full). Both
// divisions run on one bit-serial divider, 12 steps for the average and 10
// for the level; that divider sets the rate. One sample is in work at a
// time; req_ready returns the cycle after the result register loads. A
// stalled receiver holds the result register; the next sample may be
// accepted meanwhile and completes once the register frees.
// Reset: registers return to their reset values, the ring is unprimed and
// the first sample after reset fills the whole window.
module battery_level_monitor_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [blm_pkg::ADC_BITS-1:0]     req_adc_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [blm_pkg::MV_W-1:0]         rsp_avg_voltage_mv,
   output logic [blm_pkg::LVL_W-1:0]        rsp_level_tenths,
   input  logic                             csr_we,
   input  logic [blm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [blm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ACCUM, ST_SCALE, ST_AVG_GO, ST_AVG_WAIT,
      ST_LEVEL, ST_LVL_GO, ST_LVL_WAIT, ST_HOLD, ST_EMIT
   } state_type;

   state_type                          state_ff, state_in;
   logic [blm_pkg::ADC_BITS-1:0]       ring_ff [blm_pkg::WINDOW];
   logic [blm_pkg::ADC_BITS-1:0]       ring_in [blm_pkg::WINDOW];
   logic [blm_pkg::WPOS_W-1:0]         wpos_ff, wpos_in;
   logic [blm_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic                               primed_ff, primed_in;
   logic [blm_pkg::LVL_W-1:0]          held_ff, held_in;
   logic [blm_pkg::MV_W-1:0]           empty_ff, empty_in;
   logic [blm_pkg::MV_W-1:0]           full_ff, full_in;
   logic [blm_pkg::HYST_W-1:0]         hyst_ff, hyst_in;
   logic [blm_pkg::ADC_BITS-1:0]       sample_ff, sample_in;
   logic [blm_pkg::PROD_W-1:0]         prod_ff, prod_in;
   logic [blm_pkg::MV_W-1:0]           avg_ff, avg_in;
   logic [blm_pkg::LVL_W-1:0]          lvl_ff, lvl_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [blm_pkg::MV_W-1:0]           rsp_avg_ff, rsp_avg_in;
   logic [blm_pkg::LVL_W-1:0]          rsp_lvl_ff, rsp_lvl_in;

   blm_pkg::div_req_type               div_req;
   blm_pkg::div_rsp_type               div_rsp;

   logic [blm_pkg::ADC_BITS-1:0]       old_sample;
   logic [blm_pkg::SUM_W-1:0]          base_sum;
   logic [blm_pkg::MV_W-1:0]           span;
   logic [blm_pkg::MV_W-1:0]           delta;
   logic [blm_pkg::LVL_PROD_W-1:0]     lvl_prod;
   logic [blm_pkg::LVL_W-1:0]          diff;

   blm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign span     = full_ff - empty_ff;
   assign delta    = avg_ff - empty_ff;
   assign lvl_prod = blm_pkg::LVL_PROD_W'(delta) * blm_pkg::LVL_PROD_W'(blm_pkg::LEVEL_MAX);
   assign diff     = (lvl_ff >= held_ff) ? (lvl_ff - held_ff) : (held_ff - lvl_ff);

   always_comb begin
      if (primed_ff) begin
         old_sample = ring_ff[wpos_ff];
         base_sum   = sum_ff;
      end else begin
         old_sample = sample_ff;
         base_sum   = blm_pkg::SUM_W'(sample_ff) * blm_pkg::SUM_W'(blm_pkg::WINDOW);
      end
   end

   always_comb begin
      state_in     = state_ff;
      ring_in      = ring_ff;
      wpos_in      = wpos_ff;
      sum_in       = sum_ff;
      primed_in    = primed_ff;
      held_in      = held_ff;
      empty_in     = empty_ff;
      full_in      = full_ff;
      hyst_in      = hyst_ff;
      sample_in    = sample_ff;
      prod_in      = prod_ff;
      avg_in       = avg_ff;
      lvl_in       = lvl_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_lvl_in   = rsp_lvl_ff;

      div_req.start    = 1'b0;
      div_req.steps    = blm_pkg::CNT_W'(blm_pkg::Q_W);
      div_req.rem_init = blm_pkg::REM_W'(prod_ff[blm_pkg::PROD_W-1:blm_pkg::Q_W]);
      div_req.low_init = prod_ff[blm_pkg::Q_W-1:0];
      div_req.divisor  = blm_pkg::DIV_W'(blm_pkg::AVG_DIV);

      if (csr_we) begin
         unique case (csr_index)
            blm_pkg::CSR_EMPTY: empty_in = csr_wdata;
            blm_pkg::CSR_FULL:  full_in  = csr_wdata;
            blm_pkg::CSR_HYST:  hyst_in  = csr_wdata[blm_pkg::HYST_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_adc_sample;
               state_in  = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (!primed_ff) begin
               for (int k = 0; k < blm_pkg::WINDOW; k++) begin
                  ring_in[k] = sample_ff;
               end
            end
            sum_in           = base_sum - blm_pkg::SUM_W'(old_sample)
                               + blm_pkg::SUM_W'(sample_ff);
            ring_in[wpos_ff] = sample_ff;
            wpos_in          = (wpos_ff == blm_pkg::WPOS_W'(blm_pkg::WINDOW - 1))
                               ? '0 : wpos_ff + 1'b1;
            primed_in        = 1'b1;
            state_in         = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in  = blm_pkg::PROD_W'(sum_ff) * blm_pkg::PROD_W'(blm_pkg::FULL_SCALE_MV);
            state_in = ST_AVG_GO;
         end
         ST_AVG_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_rsp.done) begin
               avg_in   = (div_rsp.quotient < blm_pkg::MV_W'(blm_pkg::NOISE_FLOOR))
                          ? '0 : div_rsp.quotient;
               state_in = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            priority if (full_ff <= empty_ff || avg_ff <= empty_ff) begin
               lvl_in   = '0;
               state_in = ST_HOLD;
            end else if (delta >= span) begin
               lvl_in   = blm_pkg::LVL_W'(blm_pkg::LEVEL_MAX);
               state_in = ST_HOLD;
            end else begin
               prod_in  = blm_pkg::PROD_W'(lvl_prod);
               state_in = ST_LVL_GO;
            end
         end
         ST_LVL_GO: begin
            div_req.start    = 1'b1;
            div_req.steps    = blm_pkg::CNT_W'(blm_pkg::LVL_W);
            div_req.rem_init = blm_pkg::REM_W'(
                               prod_ff[blm_pkg::LVL_PROD_W-1:blm_pkg::LVL_W]);
            div_req.low_init = blm_pkg::Q_W'(prod_ff[blm_pkg::LVL_W-1:0])
                               << (blm_pkg::Q_W - blm_pkg::LVL_W);
            div_req.divisor  = blm_pkg::DIV_W'(span);
            state_in         = ST_LVL_WAIT;
         end
         ST_LVL_WAIT: begin
            if (div_rsp.done) begin
               lvl_in   = div_rsp.quotient[blm_pkg::LVL_W-1:0];
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (diff >= hyst_ff) begin
               held_in = lvl_ff;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = avg_ff;
               rsp_lvl_in   = held_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wpos_ff      <= '0;
         sum_ff       <= '0;
         primed_ff    <= 1'b0;
         held_ff      <= '0;
         empty_ff     <= blm_pkg::EMPTY_RESET;
         full_ff      <= blm_pkg::FULL_RESET;
         hyst_ff      <= blm_pkg::HYST_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         sum_ff       <= sum_in;
         primed_ff    <= primed_in;
         held_ff      <= held_in;
         empty_ff     <= empty_in;
         full_ff      <= full_in;
         hyst_ff      <= hyst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ring_ff    <= ring_in;
      sample_ff  <= sample_in;
      prod_ff    <= prod_in;
      avg_ff     <= avg_in;
      lvl_ff     <= lvl_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_lvl_ff <= rsp_lvl_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_avg_voltage_mv = rsp_avg_ff;
   assign rsp_level_tenths   = rsp_lvl_ff;

endmodule

### src/blm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on blm_pkg for widths and the request/response structs.
module blm_div (
   input  logic                clock,
   input  logic                reset,
   input  blm_pkg::div_req_type req,
   output blm_pkg::div_rsp_type rsp
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [blm_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [blm_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [blm_pkg::Q_W-1:0]    low_ff, low_in;
   logic [blm_pkg::Q_W-1:0]    q_ff, q_in;
   logic [blm_pkg::DIV_W-1:0]  dvs_ff, dvs_in;
   logic [blm_pkg::REM_W-1:0]  shifted;

   assign shifted = {rem_ff[blm_pkg::REM_W-2:0], low_ff[blm_pkg::Q_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps;
         rem_in  = req.rem_init;
         low_in  = req.low_init;
         q_in    = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         low_in = {low_ff[blm_pkg::Q_W-2:0], 1'b0};
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = shifted - {1'b0, dvs_ff};
            q_in   = {q_ff[blm_pkg::Q_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in   = {q_ff[blm_pkg::Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == blm_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = q_ff;

endmodule

### src/blm_checker.sv
// Port-level checker for the battery level monitor, bound to the top level.
// Depends on blm_pkg for field widths and limits.
module blm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [blm_pkg::MV_W-1:0]         rsp_avg_voltage_mv,
   input logic [blm_pkg::LVL_W-1:0]        rsp_level_tenths
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_avg_voltage_mv)
                                && $stable(rsp_level_tenths))
      else $error("result beat dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sample taken while one is in work");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level_tenths <= blm_pkg::LVL_W'(blm_pkg::LEVEL_MAX))
      else $error("level above full scale");

   a_avg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_avg_voltage_mv <= blm_pkg::MV_W'(blm_pkg::FULL_SCALE_MV)
                    && (rsp_avg_voltage_mv == '0 ||
                        rsp_avg_voltage_mv >= blm_pkg::MV_W'(blm_pkg::NOISE_FLOOR)))
      else $error("average out of range or below noise floor");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

endmodule

bind battery_level_monitor_unit blm_checker u_blm_checker (.*);
